[hw/rtl/msst_pkg.sv]
`default_nettype none

package msst_pkg;

    localparam int HOLD_W    = 16;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int IND_W     = 2;
    localparam int MODE_W    = 2;
    localparam int RUN_W     = 2;
    localparam int ROW_REGS  = 5;

    // Test mode codes as seen on the result channel.
    localparam logic [MODE_W-1:0] CODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] CODE_TEST  = 2'd1;
    localparam logic [MODE_W-1:0] CODE_ENTER = 2'd2;
    localparam logic [MODE_W-1:0] CODE_LEAVE = 2'd3;

    // Highest tested column of each row.
    typedef logic [ROW_REGS-1:0][COL_W-1:0] t_col_tbl;

    // Mode change events raised by the mode machine for the sequencer.
    typedef struct packed {
        logic enter;
        logic leave;
    } t_mode_evt;

    // Per-tick sequencer outputs.
    typedef struct packed {
        logic             drive_request;
        logic [ROW_W-1:0] slot_row;
        logic [COL_W-1:0] slot_column;
        logic             report_valid;
        logic             report_fault;
        logic [IND_W-1:0] ir_indicator;
        logic [IND_W-1:0] motor_indicator;
        logic             sweep_done;
    } t_sweep_out;

endpackage

`default_nettype wire

[hw/rtl/msst_mode.sv]
`default_nettype none

module msst_mode (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_button_held,
    input  wire logic                       i_button_released,
    input  wire logic [msst_pkg::HOLD_W-1:0] i_enter_hold_ticks,
    input  wire logic [msst_pkg::HOLD_W-1:0] i_exit_hold_ticks,
    output msst_pkg::t_mode_evt             o_evt,
    output logic [msst_pkg::MODE_W-1:0]     o_test_mode
);
    import msst_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_TEST  = 4'b0010,
        M_ENTER = 4'b0100,
        M_LEAVE = 4'b1000
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [HOLD_W-1:0] thr;

    always_comb begin
        n_mode    = r_mode;
        n_hold    = r_hold;
        o_evt     = '0;
        thr       = (r_mode == M_TEST) ? i_exit_hold_ticks : i_enter_hold_ticks;
        case (r_mode)
            M_IDLE, M_TEST: begin
                if (i_button_held) begin
                    if (r_hold < thr) begin
                        n_hold = r_hold + 1'b1;
                    end else begin
                        n_hold = '0;
                        if (r_mode == M_TEST) begin
                            n_mode      = M_LEAVE;
                            o_evt.leave = 1'b1;
                        end else begin
                            n_mode      = M_ENTER;
                            o_evt.enter = 1'b1;
                        end
                    end
                end else begin
                    n_hold = '0;
                end
            end
            M_ENTER: begin
                if (i_button_released) n_mode = M_TEST;
            end
            M_LEAVE: begin
                if (i_button_released) n_mode = M_IDLE;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (n_mode)
            M_IDLE:  o_test_mode = CODE_IDLE;
            M_TEST:  o_test_mode = CODE_TEST;
            M_ENTER: o_test_mode = CODE_ENTER;
            M_LEAVE: o_test_mode = CODE_LEAVE;
            default: o_test_mode = CODE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hold <= '0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_hold <= n_hold;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/msst_sweep.sv]
`default_nettype none

module msst_sweep #(
    parameter int ROW_COUNT = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire msst_pkg::t_mode_evt       i_evt,
    input  wire msst_pkg::t_col_tbl        i_last_col,
    input  wire logic                      i_ir_seen,
    input  wire logic                      i_drive_accepted,
    input  wire logic [msst_pkg::RUN_W-1:0] i_drive_run_state,
    input  wire logic                      i_drive_fault,
    input  wire logic                      i_position_fault,
    output msst_pkg::t_sweep_out           o_res
);
    import msst_pkg::*;

    typedef enum logic [8:0] {
        S_START  = 9'b000000001,
        S_REQ1   = 9'b000000010,
        S_RUN1   = 9'b000000100,
        S_STOP1  = 9'b000001000,
        S_REQ2   = 9'b000010000,
        S_RUN2   = 9'b000100000,
        S_STOP2  = 9'b001000000,
        S_REPORT = 9'b010000000,
        S_NEXT   = 9'b100000000
    } t_step;

    localparam logic [IND_W-1:0] IND_PASS  = 2'd1;
    localparam logic [IND_W-1:0] IND_FAIL  = 2'd2;
    localparam logic [IND_W-1:0] IND_CLEAR = 2'd3;
    localparam logic [RUN_W-1:0] RUN_IDLE    = 2'd0;
    localparam logic [RUN_W-1:0] RUN_RUNNING = 2'd2;
    localparam logic [ROW_W-1:0] LAST_ROW_END = ROW_W'(ROW_COUNT);
    localparam logic [ROW_W-1:0] TBL_ROWS     = ROW_W'(ROW_REGS);

    t_step            r_step, n_step;
    logic             r_en, n_en;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_fault, n_fault;
    logic             r_irp, n_irp;
    logic             r_motp, n_motp;
    logic [COL_W-1:0] lc;

    always_comb begin
        n_step  = r_step;
        n_en    = r_en;
        n_row   = r_row;
        n_col   = r_col;
        n_fault = r_fault;
        n_irp   = r_irp;
        n_motp  = r_motp;
        o_res   = '0;
        lc      = (r_row < TBL_ROWS) ? i_last_col[r_row] : '0;

        if (i_evt.enter) begin
            n_en   = 1'b1;
            n_step = S_START;
            n_irp  = 1'b0;
            n_motp = 1'b0;
        end
        if (i_evt.leave) begin
            n_en   = 1'b0;
            n_step = S_START;
            o_res.ir_indicator    = IND_CLEAR;
            o_res.motor_indicator = IND_CLEAR;
        end

        if (n_en) begin
            // infrared pass is latched before the step runs
            if (!n_irp && i_ir_seen) begin
                o_res.ir_indicator = IND_PASS;
                n_irp = 1'b1;
            end
            case (n_step)
                S_START: begin
                    n_row  = '0;
                    n_col  = '0;
                    n_step = S_REQ1;
                end
                S_REQ1: begin
                    o_res.drive_request = 1'b1;
                    if (i_drive_accepted) n_step = S_RUN1;
                end
                S_REQ2: begin
                    o_res.drive_request = 1'b1;
                    if (i_drive_accepted) n_step = S_RUN2;
                end
                S_RUN1: begin
                    if (i_drive_run_state == RUN_RUNNING) n_step = S_STOP1;
                end
                S_RUN2: begin
                    if (i_drive_run_state == RUN_RUNNING) n_step = S_STOP2;
                end
                S_STOP1, S_STOP2: begin
                    if (i_drive_run_state == RUN_IDLE) begin
                        if (i_drive_fault) begin
                            n_fault = 1'b1;
                            n_step  = S_REPORT;
                        end else if (n_step == S_STOP1 && i_position_fault) begin
                            // one retry on a bad stop position
                            n_step = S_REQ2;
                        end else begin
                            n_fault = 1'b0;
                            o_res.motor_indicator = IND_PASS;
                            n_motp  = 1'b1;
                            n_step  = S_REPORT;
                        end
                    end
                end
                S_REPORT: begin
                    o_res.report_valid = 1'b1;
                    o_res.report_fault = r_fault;
                    n_step = S_NEXT;
                end
                S_NEXT: begin
                    if (r_row < LAST_ROW_END) begin
                        if (r_col < lc) begin
                            n_col = r_col + 1'b1;
                        end else begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end
                        n_step = S_REQ1;
                    end else begin
                        if (!n_irp)  o_res.ir_indicator    = IND_FAIL;
                        if (!n_motp) o_res.motor_indicator = IND_FAIL;
                        n_row  = '0;
                        n_col  = '0;
                        n_step = S_START;
                        n_en   = 1'b0;
                        o_res.sweep_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            n_row  = '0;
            n_col  = '0;
            n_step = S_START;
        end

        o_res.slot_row    = n_row;
        o_res.slot_column = n_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_START;
            r_en    <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_fault <= 1'b0;
            r_irp   <= 1'b0;
            r_motp  <= 1'b0;
        end else if (i_adv) begin
            r_step  <= n_step;
            r_en    <= n_en;
            r_row   <= n_row;
            r_col   <= n_col;
            r_fault <= n_fault;
            r_irp   <= n_irp;
            r_motp  <= n_motp;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/motor_slot_self_test_sequencer_top.sv]
// Motor slot self-test sequencer.
// Input channel (i_in_valid / o_in_stall): one transfer per sampled tick of
// the test button, the goods infrared sensor and the motor driver status.
// Output channel (o_out_valid / i_out_stall): exactly one result transfer per
// input tick, in order: test mode, drive request, current slot, slot report,
// indicator commands and end-of-sweep flag.
// Path: a tick is captured in the input register, evaluated by the mode
// machine and slot sequencer, and lands in the result register, from
// which its result is offered.
// Throughput: one tick per cycle while the result channel is not stalled;
// the only loop is the registered state update of the mode machine and sequencer.
// Reset (i_rst_n, synchronous): idle mode, sweep stopped, slot zero, both
// pipeline registers empty, thresholds and per-row column limits back to
// 300, 100, 3, 10, 10, 10, 5.
// Stall: while i_out_stall holds a result, the tick behind it waits in the
// input register and o_in_stall is raised. No transfer is dropped.
// Configuration: i_cfg_we writes i_cfg_idx (0/1 enter/exit hold, 2..6 last
// column of rows 0..4); user must write with no tick in flight (unchecked).
`default_nettype none

module motor_slot_self_test_sequencer_top #(
    parameter int ROW_COUNT = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_button_held,
    input  wire logic        i_button_released,
    input  wire logic        i_ir_seen,
    input  wire logic        i_drive_accepted,
    input  wire logic [1:0]  i_drive_run_state,
    input  wire logic        i_drive_fault,
    input  wire logic        i_position_fault,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_test_mode,
    output logic             o_drive_request,
    output logic [2:0]       o_slot_row,
    output logic [3:0]       o_slot_column,
    output logic             o_report_valid,
    output logic             o_report_fault,
    output logic [1:0]       o_ir_indicator,
    output logic [1:0]       o_motor_indicator,
    output logic             o_sweep_done
);
    import msst_pkg::*;

    localparam logic [2:0] CFG_ENTER_HOLD = 3'd0;
    localparam logic [2:0] CFG_EXIT_HOLD  = 3'd1;
    localparam logic [2:0] CFG_ROW0_LAST  = 3'd2;
    localparam logic [2:0] CFG_ROW1_LAST  = 3'd3;
    localparam logic [2:0] CFG_ROW2_LAST  = 3'd4;
    localparam logic [2:0] CFG_ROW3_LAST  = 3'd5;
    localparam logic [2:0] CFG_ROW4_LAST  = 3'd6;

    // configuration registers
    logic [HOLD_W-1:0] r_enter_hold;
    logic [HOLD_W-1:0] r_exit_hold;
    t_col_tbl          r_last_col;

    // input register
    logic              r_in_valid;
    logic              r_held;
    logic              r_released;
    logic              r_ir;
    logic              r_accepted;
    logic [RUN_W-1:0]  r_run;
    logic              r_dfault;
    logic              r_pfault;

    // result register
    logic              r_out_valid;
    logic [MODE_W-1:0] r_test_mode;
    t_sweep_out        r_res;

    logic              out_free;
    logic              adv;
    logic              in_xfer;
    t_mode_evt         evt;
    logic [MODE_W-1:0] n_test_mode;
    t_sweep_out        n_res;

    // result register frees when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_hold <= HOLD_W'(300);
            r_exit_hold  <= HOLD_W'(100);
            r_last_col   <= {COL_W'(5), COL_W'(10), COL_W'(10), COL_W'(10), COL_W'(3)};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTER_HOLD: r_enter_hold  <= i_cfg_data;
                CFG_EXIT_HOLD:  r_exit_hold   <= i_cfg_data;
                CFG_ROW0_LAST:  r_last_col[0] <= i_cfg_data[COL_W-1:0];
                CFG_ROW1_LAST:  r_last_col[1] <= i_cfg_data[COL_W-1:0];
                CFG_ROW2_LAST:  r_last_col[2] <= i_cfg_data[COL_W-1:0];
                CFG_ROW3_LAST:  r_last_col[3] <= i_cfg_data[COL_W-1:0];
                CFG_ROW4_LAST:  r_last_col[4] <= i_cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_held     <= i_button_held;
            r_released <= i_button_released;
            r_ir       <= i_ir_seen;
            r_accepted <= i_drive_accepted;
            r_run      <= i_drive_run_state;
            r_dfault   <= i_drive_fault;
            r_pfault   <= i_position_fault;
        end
    end

    msst_mode u_mode (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_adv              (adv),
        .i_button_held      (r_held),
        .i_button_released  (r_released),
        .i_enter_hold_ticks (r_enter_hold),
        .i_exit_hold_ticks  (r_exit_hold),
        .o_evt              (evt),
        .o_test_mode        (n_test_mode)
    );

    msst_sweep #(
        .ROW_COUNT (ROW_COUNT)
    ) u_sweep (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (adv),
        .i_evt             (evt),
        .i_last_col        (r_last_col),
        .i_ir_seen         (r_ir),
        .i_drive_accepted  (r_accepted),
        .i_drive_run_state (r_run),
        .i_drive_fault     (r_dfault),
        .i_position_fault  (r_pfault),
        .o_res             (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_test_mode <= n_test_mode;
            r_res       <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_test_mode       = r_test_mode;
    assign o_drive_request   = r_res.drive_request;
    assign o_slot_row        = r_res.slot_row;
    assign o_slot_column     = r_res.slot_column;
    assign o_report_valid    = r_res.report_valid;
    assign o_report_fault    = r_res.report_fault;
    assign o_ir_indicator    = r_res.ir_indicator;
    assign o_motor_indicator = r_res.motor_indicator;
    assign o_sweep_done      = r_res.sweep_done;

    // a fault is only ever flagged on a reported slot
    a_fault_needs_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_fault |-> o_report_valid)
        else $error("report_fault without report_valid");

    // the sweep ends with the slot pointer back at zero
    a_done_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sweep_done |-> (o_slot_row == '0) && (o_slot_column == '0))
        else $error("sweep_done with nonzero slot");

    // drives are only requested while the test is entering or running
    a_request_in_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_request |-> (o_test_mode == CODE_TEST) ||
                                           (o_test_mode == CODE_ENTER))
        else $error("drive_request outside test mode");

    // a tick held in the input register advances as soon as the output frees
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free result register");

endmodule

`default_nettype wire

[dv/motor_slot_self_test_sequencer_top_tb.sv]
module motor_slot_self_test_sequencer_top_tb;

    import msst_pkg::*;

    localparam int ROW_COUNT      = 5;
    localparam int WATCHDOG_LIMIT = 1000;

    // Register map of the write port.
    localparam logic [2:0] REG_ENTER_HOLD = 3'd0;
    localparam logic [2:0] REG_EXIT_HOLD  = 3'd1;
    localparam logic [2:0] REG_ROW0_LAST  = 3'd2;

    // Indicator commands.
    localparam logic [IND_W-1:0] IND_PASS  = 2'd1;
    localparam logic [IND_W-1:0] IND_FAIL  = 2'd2;
    localparam logic [IND_W-1:0] IND_CLEAR = 2'd3;

    // Motor driver run state.
    localparam logic [RUN_W-1:0] RUN_IDLE    = 2'd0;
    localparam logic [RUN_W-1:0] RUN_BUSY    = 2'd1;
    localparam logic [RUN_W-1:0] RUN_RUNNING = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE     = 2'd0,
        MODE_TESTING  = 2'd1,
        MODE_ENTERING = 2'd2,
        MODE_LEAVING  = 2'd3
    } mode_e;

    typedef enum logic [3:0] {
        STEP_START      = 4'd0,
        STEP_REQ        = 4'd1,
        STEP_WAIT_RUN   = 4'd2,
        STEP_WAIT_STOP  = 4'd3,
        STEP_RETRY_REQ  = 4'd4,
        STEP_RETRY_RUN  = 4'd5,
        STEP_RETRY_STOP = 4'd6,
        STEP_REPORT     = 4'd7,
        STEP_NEXT       = 4'd8
    } seq_e;

    // One sampled tick of button, sensor and driver status.
    typedef struct packed {
        logic             held;
        logic             released;
        logic             ir;
        logic             accepted;
        logic [RUN_W-1:0] run;
        logic             dfault;
        logic             pfault;
    } tick_t;

    // Outputs for one tick, in port order.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              req;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              rvalid;
        logic              rfault;
        logic [IND_W-1:0]  ir_ind;
        logic [IND_W-1:0]  mot_ind;
        logic              done;
    } tick_result_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------
    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_cfg_we          = 1'b0;
    logic [2:0]        i_cfg_idx         = '0;
    logic [15:0]       i_cfg_data        = '0;
    logic              i_in_valid        = 1'b0;
    logic              i_button_held     = 1'b0;
    logic              i_button_released = 1'b0;
    logic              i_ir_seen         = 1'b0;
    logic              i_drive_accepted  = 1'b0;
    logic [RUN_W-1:0]  i_drive_run_state = '0;
    logic              i_drive_fault     = 1'b0;
    logic              i_position_fault  = 1'b0;
    logic              i_out_stall       = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_test_mode;
    logic              o_drive_request;
    logic [2:0]        o_slot_row;
    logic [3:0]        o_slot_column;
    logic              o_report_valid;
    logic              o_report_fault;
    logic [1:0]        o_ir_indicator;
    logic [1:0]        o_motor_indicator;
    logic              o_sweep_done;

    always #5 i_clk = ~i_clk;

    motor_slot_self_test_sequencer_top #(
        .ROW_COUNT(ROW_COUNT)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_button_held     (i_button_held),
        .i_button_released (i_button_released),
        .i_ir_seen         (i_ir_seen),
        .i_drive_accepted  (i_drive_accepted),
        .i_drive_run_state (i_drive_run_state),
        .i_drive_fault     (i_drive_fault),
        .i_position_fault  (i_position_fault),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_test_mode       (o_test_mode),
        .o_drive_request   (o_drive_request),
        .o_slot_row        (o_slot_row),
        .o_slot_column     (o_slot_column),
        .o_report_valid    (o_report_valid),
        .o_report_fault    (o_report_fault),
        .o_ir_indicator    (o_ir_indicator),
        .o_motor_indicator (o_motor_indicator),
        .o_sweep_done      (o_sweep_done)
    );

    // ------------------------------------------------------------------
    // Sequencer copy: configuration (reset values) and state
    // ------------------------------------------------------------------
    logic [HOLD_W-1:0] enter_thr = 16'd300;
    logic [HOLD_W-1:0] exit_thr  = 16'd100;
    t_col_tbl          col_limit = {4'd5, 4'd10, 4'd10, 4'd10, 4'd3};

    mode_e             mode_q    = MODE_IDLE;
    logic [HOLD_W-1:0] hold_cnt  = '0;
    logic              sweeping  = 1'b0;
    seq_e              seq_at    = STEP_START;
    logic [ROW_W-1:0]  row       = '0;
    logic [COL_W-1:0]  col       = '0;
    logic              slot_bad  = 1'b0;
    logic              ir_ok     = 1'b0;
    logic              motor_ok  = 1'b0;

    tick_result_t      owed_tick_results[$];

    bit idling_on      = 1'b1;
    int ticks_sent     = 0;
    int sessions       = 0;
    int slot_reports   = 0;
    int faulted_slots  = 0;
    int full_sweeps    = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Advances the mode machine and slot sequencer by one tick. The mode
    // change and the sweep step both act on the same tick's input.
    function automatic tick_result_t run_self_test_tick(tick_t t);
        tick_result_t      r;
        logic [HOLD_W-1:0] thr;
        r = '0;
        if (mode_q == MODE_TESTING || mode_q == MODE_IDLE) begin
            thr = (mode_q == MODE_TESTING) ? exit_thr : enter_thr;
            if (t.held) begin
                if (hold_cnt < thr) begin
                    hold_cnt = hold_cnt + 1'b1;
                end else begin
                    hold_cnt = '0;
                    seq_at   = STEP_START;
                    if (mode_q == MODE_TESTING) begin
                        mode_q    = MODE_LEAVING;
                        sweeping  = 1'b0;
                        r.ir_ind  = IND_CLEAR;
                        r.mot_ind = IND_CLEAR;
                    end else begin
                        mode_q   = MODE_ENTERING;
                        sweeping = 1'b1;
                        ir_ok    = 1'b0;
                        motor_ok = 1'b0;
                    end
                end
            end else begin
                hold_cnt = '0;
            end
        end else if (mode_q == MODE_ENTERING) begin
            if (t.released) mode_q = MODE_TESTING;
        end else begin
            if (t.released) mode_q = MODE_IDLE;
        end

        if (sweeping) begin
            // infrared mark latches before the step runs
            if (!ir_ok && t.ir) begin
                r.ir_ind = IND_PASS;
                ir_ok    = 1'b1;
            end
            case (seq_at)
                STEP_START: begin
                    row    = '0;
                    col    = '0;
                    seq_at = STEP_REQ;
                end
                STEP_REQ, STEP_RETRY_REQ: begin
                    r.req = 1'b1;
                    if (t.accepted) seq_at = seq_e'(seq_at + 1'b1);
                end
                STEP_WAIT_RUN, STEP_RETRY_RUN: begin
                    if (t.run == RUN_RUNNING) seq_at = seq_e'(seq_at + 1'b1);
                end
                STEP_WAIT_STOP, STEP_RETRY_STOP: begin
                    if (t.run == RUN_IDLE) begin
                        if (t.dfault) begin
                            slot_bad = 1'b1;
                            seq_at   = STEP_REPORT;
                        end else if (seq_at == STEP_WAIT_STOP && t.pfault) begin
                            seq_at = STEP_RETRY_REQ;   // one retry only
                        end else begin
                            slot_bad  = 1'b0;
                            r.mot_ind = IND_PASS;
                            motor_ok  = 1'b1;
                            seq_at    = STEP_REPORT;
                        end
                    end
                end
                STEP_REPORT: begin
                    r.rvalid = 1'b1;
                    r.rfault = slot_bad;
                    seq_at   = STEP_NEXT;
                    slot_reports++;
                    if (slot_bad) faulted_slots++;
                end
                STEP_NEXT: begin
                    if (row < ROW_COUNT && row < ROW_REGS) begin
                        if (col < col_limit[row]) begin
                            col = col + 1'b1;
                        end else begin
                            col = '0;
                            row = row + 1'b1;
                        end
                        seq_at = STEP_REQ;
                    end else begin
                        // unlatched marks show fail at the end of the sweep
                        if (!ir_ok)    r.ir_ind  = IND_FAIL;
                        if (!motor_ok) r.mot_ind = IND_FAIL;
                        row      = '0;
                        col      = '0;
                        seq_at   = STEP_START;
                        sweeping = 1'b0;
                        r.done   = 1'b1;
                        full_sweeps++;
                    end
                end
                default: ;
            endcase
        end else begin
            row    = '0;
            col    = '0;
            seq_at = STEP_START;
        end

        r.mode = mode_q;
        r.row  = row;
        r.col  = col;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic tick_t make_tick(logic held, logic released, logic ir, logic accepted,
                                        logic [RUN_W-1:0] run, logic dfault, logic pfault);
        tick_t t;
        t = '{held, released, ir, accepted, run, dfault, pfault};
        return t;
    endfunction

    // Driver that mostly answers what the sequencer waits for, with the
    // button left alone; noise_pct of the ticks are fully random.
    function automatic tick_t driver_reply(int noise_pct, int fault_pct, int ir_pct);
        tick_t t;
        t = '0;
        if ($urandom_range(0, 99) < noise_pct) begin
            t.held     = 1'($urandom_range(0, 1));
            t.released = 1'($urandom_range(0, 1));
            t.ir       = 1'($urandom_range(0, 1));
            t.accepted = 1'($urandom_range(0, 1));
            t.run      = RUN_W'($urandom_range(0, 2));
            t.dfault   = 1'($urandom_range(0, 1));
            t.pfault   = 1'($urandom_range(0, 1));
            return t;
        end
        t.ir = ($urandom_range(0, 99) < ir_pct);
        case (seq_at)
            STEP_REQ, STEP_RETRY_REQ: begin
                t.accepted = ($urandom_range(0, 3) != 0);
                t.run      = RUN_W'($urandom_range(0, 1));
            end
            STEP_WAIT_RUN, STEP_RETRY_RUN: begin
                t.run = ($urandom_range(0, 2) != 0) ? RUN_RUNNING : RUN_BUSY;
            end
            STEP_WAIT_STOP, STEP_RETRY_STOP: begin
                t.run    = ($urandom_range(0, 2) != 0) ? RUN_IDLE : RUN_RUNNING;
                t.dfault = ($urandom_range(0, 99) < fault_pct);
                t.pfault = ($urandom_range(0, 99) < 40);
            end
            default: t.accepted = 1'($urandom_range(0, 1));
        endcase
        return t;
    endfunction

    // Scripted driver, outcome chosen by row (one slot per row):
    // row 0 clean, row 1 drive fault, row 2 position fault then clean retry,
    // row 3 position fault on both tries, row 4 position fault then drive fault.
    function automatic tick_t planned_reply();
        tick_t t;
        t = '0;
        case (seq_at)
            STEP_REQ, STEP_RETRY_REQ:      t.accepted = 1'b1;
            STEP_WAIT_RUN, STEP_RETRY_RUN: t.run = RUN_RUNNING;
            STEP_WAIT_STOP: begin
                t.dfault = (row == 3'd1);
                t.pfault = (row >= 3'd2);
            end
            STEP_RETRY_STOP: begin
                t.dfault = (row == 3'd4);
                t.pfault = (row == 3'd3);
            end
            default: ;
        endcase
        return t;
    endfunction

    // One input transfer; optional idle burst in front of it. Returns just
    // after the accepting edge, once the monitor has stepped the model.
    task automatic send_tick(input tick_t t);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_button_held     <= t.held;
        i_button_released <= t.released;
        i_ir_seen         <= t.ir;
        i_drive_accepted  <= t.accepted;
        i_drive_run_state <= t.run;
        i_drive_fault     <= t.dfault;
        i_position_fault  <= t.pfault;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        #1;
        ticks_sent++;
    endtask

    // Drop valid, wait for every owed result, then a few spare cycles.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_tick_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ENTER_HOLD: enter_thr = data;
            REG_EXIT_HOLD:  exit_thr  = data;
            default:        col_limit[idx - REG_ROW0_LAST] = data[COL_W-1:0];
        endcase
    endtask

    // Writes every register; the block is drained first.
    task automatic load_config(input logic [15:0] enter_ticks, input logic [15:0] exit_ticks,
                               input t_col_tbl lims);
        settle();
        write_reg(REG_ENTER_HOLD, enter_ticks);
        write_reg(REG_EXIT_HOLD, exit_ticks);
        for (int r = 0; r < ROW_REGS; r++)
            write_reg(3'(REG_ROW0_LAST + r), {12'd0, lims[r]});
    endtask

    // Hold the button out of testing, then let the release edge go idle.
    task automatic leave_test_mode(input int fault_pct, input int ir_pct);
        tick_t t;
        while (mode_q != MODE_IDLE) begin
            t = driver_reply(0, fault_pct, ir_pct);
            if (mode_q == MODE_TESTING) begin
                t.held     = 1'b1;
                t.released = 1'($urandom_range(0, 1));
            end else begin
                t.held     = 1'($urandom_range(0, 1));
                t.released = ($urandom_range(0, 2) == 0);
            end
            send_tick(t);
        end
    endtask

    // Full session from idle: press to enter, arm with a release, sweep
    // (capped, so long plans get cut short by a leave), then back to idle.
    task automatic run_session(input int sweep_cap, input int noise_pct,
                               input int fault_pct, input int ir_pct);
        tick_t t;
        int    n;
        while (mode_q != MODE_ENTERING) begin
            t          = driver_reply(0, fault_pct, ir_pct);
            t.held     = 1'b1;
            t.released = 1'($urandom_range(0, 1));
            send_tick(t);
        end
        repeat ($urandom_range(0, 4)) send_tick(driver_reply(noise_pct, fault_pct, ir_pct));
        if (mode_q == MODE_ENTERING) begin
            t          = driver_reply(0, fault_pct, ir_pct);
            t.held     = 1'($urandom_range(0, 1));
            t.released = 1'b1;
            send_tick(t);
        end
        n = 0;
        while (sweeping && n < sweep_cap) begin
            send_tick(driver_reply(noise_pct, fault_pct, ir_pct));
            n++;
        end
        leave_test_mode(fault_pct, ir_pct);
        sessions++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle mode: release edges with and without a press, short presses,
    // every driver field at both ends while no sweep runs.
    task automatic test_idle_button_edges();
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, RUN_IDLE,    1'b0, 1'b0));
        send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b1, RUN_RUNNING, 1'b1, 1'b1));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0, RUN_BUSY,    1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, RUN_RUNNING, 1'b1, 1'b0));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, RUN_BUSY,    1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, RUN_IDLE,    1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1, RUN_RUNNING, 1'b1, 1'b1));
    endtask

    // Reset thresholds (300 to enter, 100 to leave) and reset column plan;
    // the leave hold lands in the middle of the sweep.
    task automatic test_default_thresholds();
        run_session(40, 5, 20, 10);
    endtask

    // Thresholds of one and one slot per row, every slot outcome at least once,
    // no infrared seen so the sweep ends with an infrared fail mark.
    task automatic test_directed_sweep();
        tick_t t;
        load_config(16'd1, 16'd1, '0);
        repeat (2) begin
            t      = planned_reply();
            t.held = 1'b1;
            send_tick(t);
        end
        t          = planned_reply();
        t.released = 1'b1;
        send_tick(t);
        while (sweeping) send_tick(planned_reply());
        leave_test_mode(0, 0);
    endtask

    // Largest thresholds and column limits; long presses never enter.
    task automatic test_threshold_limits();
        tick_t t;
        load_config(16'hFFFF, 16'hFFFF, {ROW_REGS{4'hF}});
        repeat (20) begin
            t      = driver_reply(50, 20, 10);
            t.held = ($urandom_range(0, 4) != 0);
            send_tick(t);
        end
    endtask

    // Random plans, thresholds, fault and infrared rates per session.
    task automatic test_random_sessions(input int upto);
        t_col_tbl lims;
        int       fault_pct;
        int       ir_pct;
        logic [15:0] enter_ticks;
        logic [15:0] exit_ticks;
        while (ticks_sent < upto) begin
            for (int r = 0; r < ROW_REGS; r++) begin
                case ($urandom_range(0, 5))
                    0:       lims[r] = 4'd0;
                    1:       lims[r] = 4'hF;
                    default: lims[r] = COL_W'($urandom_range(0, 3));
                endcase
            end
            enter_ticks = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(1, 6));
            exit_ticks  = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0:       fault_pct = 100;
                1:       fault_pct = 0;
                default: fault_pct = 25;
            endcase
            case ($urandom_range(0, 2))
                0:       ir_pct = 0;
                1:       ir_pct = 3;
                default: ir_pct = 30;
            endcase
            idling_on = ($urandom_range(0, 3) != 0);
            load_config(enter_ticks, exit_ticks, lims);
            run_session(200, 10, fault_pct, ir_pct);
        end
    endtask

    // Back-to-back transfers on both sides to close the run.
    task automatic test_steady_stream();
        t_col_tbl lims;
        idling_on = 1'b0;
        for (int r = 0; r < ROW_REGS; r++) lims[r] = COL_W'($urandom_range(0, 2));
        load_config(16'd2, 16'd3, lims);
        run_session(200, 5, 25, 10);
    endtask

    // ------------------------------------------------------------------
    // Output stall: random bursts while idling is on
    // ------------------------------------------------------------------
    initial begin : out_stall_gen
        int left;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left > 0) begin
                left--;
                i_out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                left = $urandom_range(1, 10) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking, prediction on input transfer, watchdog.
    // Results are checked before this edge's input is predicted, so a
    // result can never be matched against a tick accepted at the same edge.
    // ------------------------------------------------------------------
    task automatic show_result(input string tag, input tick_result_t r);
        $display("  %s mode=%0d req=%0d slot=%0d.%0d report=%0d fault=%0d ir=%0d motor=%0d done=%0d",
                 tag, r.mode, r.req, r.row, r.col, r.rvalid, r.rfault,
                 r.ir_ind, r.mot_ind, r.done);
    endtask

    always @(posedge i_clk) begin : tick_monitor
        tick_result_t got;
        tick_result_t want;
        tick_t        seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_test_mode, o_drive_request, o_slot_row, o_slot_column,
                       o_report_valid, o_report_fault, o_ir_indicator,
                       o_motor_indicator, o_sweep_done};
                results_seen++;
                if (owed_tick_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d arrived with no tick outstanding", results_seen);
                        show_result("got", got);
                    end
                end else begin
                    want = owed_tick_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d differs", results_seen);
                            show_result("exp", want);
                            show_result("got", got);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                seen = {i_button_held, i_button_released, i_ir_seen, i_drive_accepted,
                        i_drive_run_state, i_drive_fault, i_position_fault};
                owed_tick_results.push_back(run_self_test_tick(seen));
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, owed_tick_results.size());
                $display("motor_slot_self_test_sequencer_top_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_button_edges();
        test_default_thresholds();
        test_directed_sweep();
        test_threshold_limits();
        test_random_sessions(600);
        test_steady_stream();
        settle();

        $display("covered %0d ticks in %0d test sessions, %0d complete sweeps",
                 ticks_sent, sessions, full_sweeps);
        $display("%0d slot reports (%0d with a fault), %0d mismatches",
                 slot_reports, faulted_slots, mismatch_count);
        if (mismatch_count == 0 && owed_tick_results.size() == 0) begin
            $display("motor_slot_self_test_sequencer_top_tb passed");
        end else begin
            $display("motor_slot_self_test_sequencer_top_tb failed");
        end
        $finish;
    end

endmodule
